### rtl/core/brz_pkg.sv
// ============================================================================
// brz_pkg: shared definitions for the line rasterizer
// Coordinate, delta, error and address widths, stream word layouts and the
// item mode codes.
// ============================================================================
`default_nettype none

package brz_pkg;

  // Coordinate width; every delta and error width follows from it.
  localparam int COORD_BITS  = 10;
  localparam int DELTA_BITS  = COORD_BITS + 1;  // doubled absolute delta
  localparam int ERR_BITS    = COORD_BITS + 3;  // signed error term
  localparam int PITCH_BITS  = 11;
  localparam int ADDR_BITS   = 20;
  localparam int COLOUR_BITS = 8;
  localparam int PROD_BITS   = COORD_BITS + PITCH_BITS;

  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(320);

  // Input word: start_x, start_y, end_x, end_y, colour from bit 0 up.
  localparam int IN_SX_LSB     = 0;
  localparam int IN_SY_LSB     = COORD_BITS;
  localparam int IN_EX_LSB     = 2 * COORD_BITS;
  localparam int IN_EY_LSB     = 3 * COORD_BITS;
  localparam int IN_COL_LSB    = 4 * COORD_BITS;
  localparam int IN_USED_BITS  = 4 * COORD_BITS + COLOUR_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  // Output word: pixel_x, pixel_y, pixel_address, pixel_colour from bit 0 up.
  localparam int OUT_X_LSB     = 0;
  localparam int OUT_Y_LSB     = COORD_BITS;
  localparam int OUT_ADDR_LSB  = 2 * COORD_BITS;
  localparam int OUT_COL_LSB   = 2 * COORD_BITS + ADDR_BITS;
  localparam int OUT_USED_BITS = 2 * COORD_BITS + ADDR_BITS + COLOUR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // Item mode carried in tuser.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

endpackage

`default_nettype wire

### rtl/core/bresenham_line_rasterizer.sv
// ============================================================================
// bresenham_line_rasterizer: integer line rasterizer for a linear frame buffer
// A load word latches two endpoints and a colour and emits the first pixel;
// each step word emits the next pixel with its frame buffer address.
// ============================================================================
//
//   channel   direction  tdata fields (low bit up)                  tuser / tlast
//   s_axis    in         start_x, start_y, end_x, end_y, colour     tuser = mode
//   m_axis    out        pixel_x, pixel_y, pixel_address, colour    tlast = last_pixel
//   cfg       in         row_pitch (written when cfg_wen is high)   -
//
// For each word, the error update, cursor move and the
// row-times-pitch multiply sit between the line state and the output register.
// A new word is taken every cycle while the output register is empty or being
// drained. A step word with no active line produces no output word.
// rst is synchronous and clears the line state and the output valid flag.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration: row pitch.
  input  wire logic                                cfg_wen,
  input  wire logic [brz_pkg::PITCH_BITS-1:0]      cfg_wdata,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // start_x, start_y, end_x, end_y, colour
  input  wire logic [brz_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // mode
  input  wire logic                                s_axis_tuser,
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pixel_x, pixel_y, pixel_address, pixel_colour
  output logic [brz_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
  // last_pixel
  output logic                                     m_axis_tlast
);

  localparam int C = brz_pkg::COORD_BITS;
  localparam int D = brz_pkg::DELTA_BITS;
  localparam int E = brz_pkg::ERR_BITS;

  // Configuration and line state.
  logic [brz_pkg::PITCH_BITS-1:0]  row_pitch;
  logic [C-1:0]                    cursor_x, cursor_y, target_x, target_y;
  logic signed [E-1:0]             error_term;
  logic [D-1:0]                    double_dx, double_dy;
  logic                            x_step_negative, y_step_negative, x_is_major;
  logic                            line_active;
  logic [brz_pkg::COLOUR_BITS-1:0] line_colour;

  logic [C-1:0]                    cursor_x_next, cursor_y_next;
  logic [C-1:0]                    target_x_next, target_y_next;
  logic signed [E-1:0]             error_term_next;
  logic [D-1:0]                    double_dx_next, double_dy_next;
  logic                            x_step_negative_next, y_step_negative_next;
  logic                            x_is_major_next, line_active_next;
  logic [brz_pkg::COLOUR_BITS-1:0] line_colour_next;
  logic                            last_next;
  logic                            emit;

  // Input fields.
  logic [C-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [brz_pkg::COLOUR_BITS-1:0] in_colour;
  logic accept;

  assign in_sx     = s_axis_tdata[brz_pkg::IN_SX_LSB +: C];
  assign in_sy     = s_axis_tdata[brz_pkg::IN_SY_LSB +: C];
  assign in_ex     = s_axis_tdata[brz_pkg::IN_EX_LSB +: C];
  assign in_ey     = s_axis_tdata[brz_pkg::IN_EY_LSB +: C];
  assign in_colour = s_axis_tdata[brz_pkg::IN_COL_LSB +: brz_pkg::COLOUR_BITS];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Load setup: signed deltas, directions and doubled magnitudes.
  logic signed [C:0] delta_x, delta_y;
  logic [C-1:0]      abs_dx, abs_dy;
  logic [D-1:0]      load_ddx, load_ddy;

  always_comb begin
    delta_x  = $signed({1'b0, in_ex}) - $signed({1'b0, in_sx});
    delta_y  = $signed({1'b0, in_ey}) - $signed({1'b0, in_sy});
    abs_dx   = delta_x[C] ? C'(-delta_x) : delta_x[C-1:0];
    abs_dy   = delta_y[C] ? C'(-delta_y) : delta_y[C-1:0];
    load_ddx = {abs_dx, 1'b0};
    load_ddy = {abs_dy, 1'b0};
  end

  // Step: decide the minor move from the error term, then advance the cursor.
  logic                err_pos, err_zero, minor_step;
  logic [D-1:0]        d_major, d_minor;
  logic signed [E-1:0] err_after_minor;
  logic [C-1:0]        step_x, step_y;

  always_comb begin
    err_pos   = !error_term[E-1] && (error_term != '0);
    err_zero  = (error_term == '0);
    d_major   = x_is_major ? double_dx : double_dy;
    d_minor   = x_is_major ? double_dy : double_dx;
    minor_step = err_pos ||
                 (err_zero && !(x_is_major ? x_step_negative : y_step_negative));
    err_after_minor = minor_step ? error_term - $signed(E'(d_major)) : error_term;
    step_x = x_step_negative ? cursor_x - C'(1) : cursor_x + C'(1);
    step_y = y_step_negative ? cursor_y - C'(1) : cursor_y + C'(1);
  end

  // Next line state and whether an output word is produced.
  always_comb begin
    cursor_x_next        = cursor_x;
    cursor_y_next        = cursor_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    error_term_next      = error_term;
    double_dx_next       = double_dx;
    double_dy_next       = double_dy;
    x_step_negative_next = x_step_negative;
    y_step_negative_next = y_step_negative;
    x_is_major_next      = x_is_major;
    line_active_next     = line_active;
    line_colour_next     = line_colour;
    last_next            = 1'b0;
    emit                 = 1'b0;
    if (accept) begin
      if (s_axis_tuser == brz_pkg::MODE_LOAD) begin
        cursor_x_next        = in_sx;
        cursor_y_next        = in_sy;
        target_x_next        = in_ex;
        target_y_next        = in_ey;
        line_colour_next     = in_colour;
        x_step_negative_next = delta_x[C];
        y_step_negative_next = delta_y[C];
        double_dx_next       = load_ddx;
        double_dy_next       = load_ddy;
        x_is_major_next      = load_ddx > load_ddy;
        if (load_ddx > load_ddy) begin
          error_term_next = $signed(E'(load_ddy)) - $signed(E'(abs_dx));
          last_next       = (in_sx == in_ex);
        end else begin
          error_term_next = $signed(E'(load_ddx)) - $signed(E'(abs_dy));
          last_next       = (in_sy == in_ey);
        end
        line_active_next = !last_next;
        emit             = 1'b1;
      end else if (line_active) begin
        error_term_next = err_after_minor + $signed(E'(d_minor));
        if (x_is_major) begin
          cursor_x_next = step_x;
          cursor_y_next = minor_step ? step_y : cursor_y;
          last_next     = (step_x == target_x);
        end else begin
          cursor_y_next = step_y;
          cursor_x_next = minor_step ? step_x : cursor_x;
          last_next     = (step_y == target_y);
        end
        line_active_next = !last_next;
        emit             = 1'b1;
      end
    end
  end

  // Pixel address from the new cursor: row times pitch plus column.
  logic [brz_pkg::PROD_BITS-1:0] row_offset;
  logic [brz_pkg::ADDR_BITS-1:0] pixel_address_next;
  logic [brz_pkg::OUT_DATA_BITS-1:0] out_word_next;

  always_comb begin
    row_offset = brz_pkg::PROD_BITS'(cursor_y_next) * brz_pkg::PROD_BITS'(row_pitch);
    pixel_address_next = brz_pkg::ADDR_BITS'(row_offset + brz_pkg::PROD_BITS'(cursor_x_next));
  end

  // Output word packing, unused bits held at zero.
  always_comb begin
    out_word_next = '0;
    out_word_next[brz_pkg::OUT_X_LSB +: C] = cursor_x_next;
    out_word_next[brz_pkg::OUT_Y_LSB +: C] = cursor_y_next;
    out_word_next[brz_pkg::OUT_ADDR_LSB +: brz_pkg::ADDR_BITS] = pixel_address_next;
    out_word_next[brz_pkg::OUT_COL_LSB +: brz_pkg::COLOUR_BITS] = line_colour_next;
  end

  // Configuration register and line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= brz_pkg::PITCH_RESET;
      cursor_x        <= '0;
      cursor_y        <= '0;
      target_x        <= '0;
      target_y        <= '0;
      error_term      <= '0;
      double_dx       <= '0;
      double_dy       <= '0;
      x_step_negative <= 1'b0;
      y_step_negative <= 1'b0;
      x_is_major      <= 1'b0;
      line_active     <= 1'b0;
      line_colour     <= '0;
    end else begin
      if (cfg_wen) begin
        row_pitch <= cfg_wdata;
      end
      cursor_x        <= cursor_x_next;
      cursor_y        <= cursor_y_next;
      target_x        <= target_x_next;
      target_y        <= target_y_next;
      error_term      <= error_term_next;
      double_dx       <= double_dx_next;
      double_dy       <= double_dy_next;
      x_step_negative <= x_step_negative_next;
      y_step_negative <= y_step_negative_next;
      x_is_major      <= x_is_major_next;
      line_active     <= line_active_next;
      line_colour     <= line_colour_next;
    end
  end

  // Output register: valid flag under reset, payload loaded on each new pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= out_word_next;
      m_axis_tlast <= last_next;
    end
  end

endmodule

`default_nettype wire

### test/tb.sv
// ============================================================================
// tb: regression bench for bresenham_line_rasterizer
// Streams load and step words into the rasterizer, predicts every pixel with
// an independent line tracer, and checks each output word field by field.
// Runs a directed opener, then random line sequences under several row
// pitches and several idle and stall patterns.
// ============================================================================

module tb;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int LINES_PER_PHASE = 180;
  localparam int MAX_COORD = (1 << brz_pkg::COORD_BITS) - 1;

  // One input word as the sender sees it.
  typedef struct {
    brz_pkg::mode_t                  mode;
    logic [brz_pkg::COORD_BITS-1:0]  sx, sy, ex, ey;
    logic [brz_pkg::COLOUR_BITS-1:0] colour;
  } line_word_t;

  // One predicted pixel.
  typedef struct {
    logic [brz_pkg::COORD_BITS-1:0]  x, y;
    logic [brz_pkg::ADDR_BITS-1:0]   addr;
    logic [brz_pkg::COLOUR_BITS-1:0] colour;
    logic                            last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [brz_pkg::PITCH_BITS-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [brz_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [brz_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tlast;

  bresenham_line_rasterizer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  line_word_t pending_words[$];
  pixel_t expected_pixels[$];

  // Tracer state, kept apart from the block.
  logic [brz_pkg::PITCH_BITS-1:0]  row_pitch_now = brz_pkg::PITCH_RESET;
  logic [brz_pkg::COORD_BITS-1:0]  cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
  int                              err_acc = 0, twice_dx = 0, twice_dy = 0;
  logic                            x_back = 1'b0, y_back = 1'b0, x_leads = 1'b0;
  logic                            tracing = 1'b0;
  logic [brz_pkg::COLOUR_BITS-1:0] ink = '0;

  // Pacing knobs, changed between phases.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holds_requested = 0;

  logic in_taken = 1'b0;
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned pixels_checked = 0;
  int unsigned pitch_writes = 0;
  int unsigned quiet_cycles = 0;

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on %s at pixel %0d: got 0x%0h, want 0x%0h",
             what, pixels_checked, got, want);
  endtask

  // Records the pixel at the cursor as the next expected output word.
  task automatic note_pixel(input logic fin);
    logic [31:0] prod;
    prod = 32'(cur_y) * 32'(row_pitch_now) + 32'(cur_x);
    expected_pixels.push_back(pixel_t'{cur_x, cur_y, prod[brz_pkg::ADDR_BITS-1:0],
                                       ink, fin});
  endtask

  // Advances the line tracer by one accepted word.
  task automatic trace_line_word(input line_word_t w);
    int dx, dy;
    logic fin;
    if (w.mode == brz_pkg::MODE_LOAD) begin
      cur_x = w.sx;
      cur_y = w.sy;
      tgt_x = w.ex;
      tgt_y = w.ey;
      ink = w.colour;
      dx = int'(tgt_x) - int'(cur_x);
      dy = int'(tgt_y) - int'(cur_y);
      x_back = dx < 0;
      y_back = dy < 0;
      twice_dx = 2 * (dx < 0 ? -dx : dx);
      twice_dy = 2 * (dy < 0 ? -dy : dy);
      x_leads = twice_dx > twice_dy;
      if (x_leads) begin
        err_acc = twice_dy - twice_dx / 2;
        fin = cur_x == tgt_x;
      end else begin
        err_acc = twice_dx - twice_dy / 2;
        fin = cur_y == tgt_y;
      end
      tracing = !fin;
      note_pixel(fin);
    end else if (tracing) begin
      // On a zero error the minor axis moves only for a forward major axis.
      if (x_leads) begin
        if (err_acc > 0 || (err_acc == 0 && !x_back)) begin
          cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
          err_acc -= twice_dx;
        end
        cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
        err_acc += twice_dy;
        fin = cur_x == tgt_x;
      end else begin
        if (err_acc > 0 || (err_acc == 0 && !y_back)) begin
          cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
          err_acc -= twice_dy;
        end
        cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
        err_acc += twice_dx;
        fin = cur_y == tgt_y;
      end
      if (fin) tracing = 1'b0;
      note_pixel(fin);
    end
  endtask

  // Sender: offers the next pending word once the current one is taken.
  always @(negedge clk) begin
    line_word_t w;
    logic [brz_pkg::IN_DATA_BITS-1:0] packed_in;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        w = pending_words.pop_front();
        packed_in = '0;
        packed_in[brz_pkg::IN_SX_LSB +: brz_pkg::COORD_BITS] = w.sx;
        packed_in[brz_pkg::IN_SY_LSB +: brz_pkg::COORD_BITS] = w.sy;
        packed_in[brz_pkg::IN_EX_LSB +: brz_pkg::COORD_BITS] = w.ex;
        packed_in[brz_pkg::IN_EY_LSB +: brz_pkg::COORD_BITS] = w.ey;
        packed_in[brz_pkg::IN_COL_LSB +: brz_pkg::COLOUR_BITS] = w.colour;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.mode;
        s_axis_tdata <= packed_in;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    int unsigned hold_left;
    int unsigned holds_done;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_done != holds_requested) begin
      m_axis_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end else begin
      m_axis_tready <= !rst && $urandom_range(0, 99) >= receiver_stall_pct;
    end
  end

  // Monitor: checks output words, then feeds accepted input words to the tracer.
  always @(posedge clk) begin
    pixel_t want;
    line_word_t seen;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_wen) row_pitch_now = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("unexpected pixel",
                        m_axis_tdata[brz_pkg::OUT_ADDR_LSB +: brz_pkg::ADDR_BITS], 0);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata[brz_pkg::OUT_X_LSB +: brz_pkg::COORD_BITS] !== want.x)
            flag_mismatch("pixel_x",
                          m_axis_tdata[brz_pkg::OUT_X_LSB +: brz_pkg::COORD_BITS], want.x);
          if (m_axis_tdata[brz_pkg::OUT_Y_LSB +: brz_pkg::COORD_BITS] !== want.y)
            flag_mismatch("pixel_y",
                          m_axis_tdata[brz_pkg::OUT_Y_LSB +: brz_pkg::COORD_BITS], want.y);
          if (m_axis_tdata[brz_pkg::OUT_ADDR_LSB +: brz_pkg::ADDR_BITS] !== want.addr)
            flag_mismatch("pixel_address",
                          m_axis_tdata[brz_pkg::OUT_ADDR_LSB +: brz_pkg::ADDR_BITS],
                          want.addr);
          if (m_axis_tdata[brz_pkg::OUT_COL_LSB +: brz_pkg::COLOUR_BITS] !== want.colour)
            flag_mismatch("pixel_colour",
                          m_axis_tdata[brz_pkg::OUT_COL_LSB +: brz_pkg::COLOUR_BITS],
                          want.colour);
          if (m_axis_tlast !== want.last)
            flag_mismatch("last_pixel", m_axis_tlast, want.last);
          pixels_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.mode = brz_pkg::mode_t'(s_axis_tuser);
        seen.sx = s_axis_tdata[brz_pkg::IN_SX_LSB +: brz_pkg::COORD_BITS];
        seen.sy = s_axis_tdata[brz_pkg::IN_SY_LSB +: brz_pkg::COORD_BITS];
        seen.ex = s_axis_tdata[brz_pkg::IN_EX_LSB +: brz_pkg::COORD_BITS];
        seen.ey = s_axis_tdata[brz_pkg::IN_EY_LSB +: brz_pkg::COORD_BITS];
        seen.colour = s_axis_tdata[brz_pkg::IN_COL_LSB +: brz_pkg::COLOUR_BITS];
        trace_line_word(seen);
        words_in++;
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("bresenham_line_rasterizer regression: fail");
      $finish;
    end
  end

  task automatic queue_word(input brz_pkg::mode_t mode, input int sx, input int sy,
                            input int ex, input int ey, input int colour);
    line_word_t w;
    w.mode = mode;
    w.sx = brz_pkg::COORD_BITS'(sx);
    w.sy = brz_pkg::COORD_BITS'(sy);
    w.ex = brz_pkg::COORD_BITS'(ex);
    w.ey = brz_pkg::COORD_BITS'(ey);
    w.colour = brz_pkg::COLOUR_BITS'(colour);
    pending_words.push_back(w);
  endtask

  // Step words carry junk in the endpoint and colour fields.
  task automatic queue_steps(input int n);
    repeat (n) queue_word(brz_pkg::MODE_STEP, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
  endtask

  // Coordinates favor the screen edges now and then.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 3);
    if (r == 1) return $urandom_range(MAX_COORD - 3, MAX_COORD);
    return $urandom_range(0, MAX_COORD);
  endfunction

  function automatic int nudge(input int base, input int d);
    if (base + d < 0 || base + d > MAX_COORD) return base - d;
    return base + d;
  endfunction

  // Mostly complete short lines; some cut short, overrun, long or stray steps.
  task automatic queue_random_lines(input int budget);
    int made, pick, len, dx, dy, sx, sy, ex, ey, major, steps;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_steps($urandom_range(1, 3));
      end else begin
        sx = pick_coord();
        sy = pick_coord();
        if (pick < 12) begin
          ex = $urandom_range(0, MAX_COORD);
          ey = $urandom_range(0, MAX_COORD);
        end else begin
          len = $urandom_range(0, 14);
          dx = $urandom_range(0, 2 * len);
          dy = $urandom_range(0, 2 * len);
          ex = nudge(sx, dx - len);
          ey = nudge(sy, dy - len);
        end
        queue_word(brz_pkg::MODE_LOAD, sx, sy, ex, ey, $urandom);
        dx = ex > sx ? ex - sx : sx - ex;
        dy = ey > sy ? ey - sy : sy - ey;
        major = dx > dy ? dx : dy;
        if (pick < 12) steps = $urandom_range(0, major < 24 ? major : 24);
        else if (pick < 22) steps = $urandom_range(0, major);
        else if (pick < 30) steps = major + $urandom_range(1, 3);
        else steps = major;
        queue_steps(steps);
        made += 1 + (steps < major ? steps : major);
      end
    end
  endtask

  // Waits until every word is taken and every pixel is out, then a little more.
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_words.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pitch(input int unsigned value);
    cfg_wen <= 1'b1;
    cfg_wdata <= brz_pkg::PITCH_BITS'(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    #1;
    pitch_writes++;
  endtask

  initial begin
    int unsigned pitch_plan[6];
    int unsigned sender_plan[4];
    int unsigned receiver_plan[4];
    pitch_plan = '{1, 1024, 2047, 0, 0, 0};
    pitch_plan[4] = $urandom_range(1, 1024);
    pitch_plan[5] = $urandom_range(0, 2047);
    sender_plan = '{0, 83, 0, 10};
    receiver_plan = '{0, 0, 83, 10};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    #1;

    // Directed opener at the reset row pitch.
    sender_idle_pct = 10;
    receiver_stall_pct = 10;
    queue_word(brz_pkg::MODE_LOAD, 0, 0, 0, 0, 0);         // single point line
    queue_steps(1);                                        // step with no line
    queue_word(brz_pkg::MODE_LOAD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 255);
    queue_word(brz_pkg::MODE_LOAD, 10, 10, 14, 12, 'h5A);  // zero error, forward x
    queue_steps(4);
    queue_word(brz_pkg::MODE_LOAD, 14, 12, 10, 10, 'hA5);  // zero error, backward x
    queue_steps(5);                                        // last one finds no line
    // Diagonal, y leads.
    queue_word(brz_pkg::MODE_LOAD, MAX_COORD, 0, MAX_COORD - 3, 3, 'h33);
    queue_steps(1);
    // Abandons the diagonal.
    queue_word(brz_pkg::MODE_LOAD, 0, MAX_COORD, 1, MAX_COORD - 3, 'hCC);
    queue_steps(3);
    // Long line cut short.
    queue_word(brz_pkg::MODE_LOAD, 0, 0, MAX_COORD, MAX_COORD, 'h0F);
    queue_steps(2);
    queue_word(brz_pkg::MODE_LOAD, 5, 5, 5, 5, 'hF0);

    // Random phases, one row pitch and one pacing pattern each.
    for (int p = 0; p < 6; p++) begin
      drain();
      write_pitch(pitch_plan[p]);
      sender_idle_pct = sender_plan[p % 4];
      receiver_stall_pct = receiver_plan[p % 4];
      queue_random_lines(LINES_PER_PHASE);
      if (p == 4) holds_requested++;
    end

    drain();
    repeat (8) @(posedge clk);
    #1;
    $display("covered %0d input words and %0d checked pixels over %0d row pitch settings",
             words_in, pixels_checked, pitch_writes + 1);
    $display("mismatches seen: %0d", errors);
    if (errors == 0) begin
      $display("bresenham_line_rasterizer regression: pass");
    end else begin
      $display("bresenham_line_rasterizer regression: fail");
    end
    $finish;
  end

endmodule
